@@ hw/rtl/rekd_pkg.sv @@
// Shared types and constants for the rotary encoder / key event decoder.
// No dependencies; used by rekd_tick_logic and the top level.
package rekd_pkg;

    typedef enum logic [2:0] {
        EVT_NONE  = 3'd0,
        EVT_UP    = 3'd1,
        EVT_DOWN  = 3'd2,
        EVT_ENTER = 3'd3,
        EVT_LONG  = 3'd4
    } evt_code_t;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_BUTTON_LAYOUT    = 2'd0;
    localparam logic [1:0] REG_SWAP_LINES       = 2'd1;
    localparam logic [1:0] REG_LONG_PRESS_TICKS = 2'd2;

    localparam logic [7:0] LONG_PRESS_RESET = 8'd100;
    localparam logic [7:0] HOLD_MAX         = 8'hFF;

    typedef struct packed {
        logic       button_layout;
        logic       swap_lines;
        logic [7:0] long_press_ticks;
    } rekd_cfg_t;

    typedef struct packed {
        logic       prev_line_a;
        logic       prev_line_b;
        logic       prev_key;
        logic       key_held;
        logic [7:0] hold_count;
    } rekd_state_t;

endpackage

@@ hw/rtl/rekd_tick_logic.sv @@
// Combinational next-state and event logic for one sample tick.
// Depends on rekd_pkg.
module rekd_tick_logic (
    input  rekd_pkg::rekd_cfg_t   cfg,
    input  rekd_pkg::rekd_state_t state_cur,
    input  logic                  line_a,
    input  logic                  line_b,
    input  logic                  key_level,
    output rekd_pkg::rekd_state_t state_nxt,
    output rekd_pkg::evt_code_t   evt
);

    logic       a;
    logic       b;
    logic       held;
    logic [7:0] hold;

    always_comb
    begin
        a    = cfg.swap_lines ? line_b : line_a;
        b    = cfg.swap_lines ? line_a : line_b;
        held = state_cur.key_held;
        hold = state_cur.hold_count;
        evt  = rekd_pkg::EVT_NONE;

        if (held && hold != rekd_pkg::HOLD_MAX)
        begin
            hold = hold + 8'd1;
        end

        if (state_cur.prev_key != key_level)
        begin
            if (!key_level)
            begin
                held = 1'b1;
                hold = 8'd0;
            end
            else if (held)
            begin
                if (hold < cfg.long_press_ticks)
                begin
                    evt = rekd_pkg::EVT_ENTER;
                end
                held = 1'b0;
            end
        end

        if (held && hold >= cfg.long_press_ticks)
        begin
            evt  = rekd_pkg::EVT_LONG;
            held = 1'b0;
        end

        // line events override key events raised in the same tick
        if (!cfg.button_layout)
        begin
            if (state_cur.prev_line_a && !a)
            begin
                evt = b ? rekd_pkg::EVT_UP : rekd_pkg::EVT_DOWN;
            end
        end
        else
        begin
            if (state_cur.prev_line_a && !a)
            begin
                evt = rekd_pkg::EVT_UP;
            end
            if (state_cur.prev_line_b && !b)
            begin
                evt = rekd_pkg::EVT_DOWN;
            end
        end

        state_nxt.prev_line_a = a;
        state_nxt.prev_line_b = b;
        state_nxt.prev_key    = key_level;
        state_nxt.key_held    = held;
        state_nxt.hold_count  = hold;
    end

endmodule

@@ hw/rtl/rotary_encoder_key_event_decoder_top.sv @@
// Top level of the rotary encoder / key event decoder: stream ports, APB registers,
// state and result registers. Depends on rekd_pkg and rekd_tick_logic.
//
// Each request is either a sample tick (tuser = 0) or a read-and-clear of the pending
// event (tuser = 1), and yields exactly one result. The block takes one request per
// clock and returns its result in the next cycle from a single result register; the
// input side stays ready while that register is empty or is being drained in the same
// cycle, so throughput is one request per clock whenever the output side is ready.
// Write the registers only while no request is in flight.
module rotary_encoder_key_event_decoder_top (
    input  logic        clk,
    input  logic        rst_n,
    // stream input
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [0] line_a, [1] line_b, [2] key_level, rest 0
    input  logic        s_axis_tuser,   // [0] mode: 0 sample tick, 1 read and clear
    // stream output
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] event_code, rest 0
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    rekd_pkg::rekd_cfg_t   cfg_reg;
    rekd_pkg::rekd_cfg_t   cfg_next;
    rekd_pkg::rekd_state_t state_reg;
    rekd_pkg::rekd_state_t state_next;
    rekd_pkg::rekd_state_t tick_state;
    rekd_pkg::evt_code_t   tick_evt;
    rekd_pkg::evt_code_t   pending_reg;
    rekd_pkg::evt_code_t   pending_next;
    rekd_pkg::evt_code_t   out_evt_reg;
    rekd_pkg::evt_code_t   out_evt_next;
    logic                  out_valid_reg;
    logic                  out_valid_next;
    logic                  in_accept;
    logic                  cfg_write;

    assign pready        = 1'b1;
    assign cfg_write     = psel & penable & pwrite & pready;
    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_accept     = s_axis_tvalid & s_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {5'd0, out_evt_reg};

    rekd_tick_logic u_tick (
        .cfg       (cfg_reg),
        .state_cur (state_reg),
        .line_a    (s_axis_tdata[0]),
        .line_b    (s_axis_tdata[1]),
        .key_level (s_axis_tdata[2]),
        .state_nxt (tick_state),
        .evt       (tick_evt)
    );

    // register file
    always_comb
    begin
        cfg_next = cfg_reg;
        prdata   = 32'd0;
        unique case (paddr[3:2])
            rekd_pkg::REG_BUTTON_LAYOUT:
            begin
                prdata = {31'd0, cfg_reg.button_layout};
                if (cfg_write)
                begin
                    cfg_next.button_layout = pwdata[0];
                end
            end
            rekd_pkg::REG_SWAP_LINES:
            begin
                prdata = {31'd0, cfg_reg.swap_lines};
                if (cfg_write)
                begin
                    cfg_next.swap_lines = pwdata[0];
                end
            end
            rekd_pkg::REG_LONG_PRESS_TICKS:
            begin
                prdata = {24'd0, cfg_reg.long_press_ticks};
                if (cfg_write)
                begin
                    cfg_next.long_press_ticks = pwdata[7:0];
                end
            end
            default:
            begin
                prdata = 32'd0;
            end
        endcase
    end

    // request handling
    always_comb
    begin
        state_next     = state_reg;
        pending_next   = pending_reg;
        out_evt_next   = out_evt_reg;
        out_valid_next = out_valid_reg && !m_axis_tready;
        if (in_accept)
        begin
            out_valid_next = 1'b1;
            if (s_axis_tuser)
            begin
                out_evt_next = pending_reg;
                pending_next = rekd_pkg::EVT_NONE;
            end
            else
            begin
                out_evt_next = tick_evt;
                state_next   = tick_state;
                if (tick_evt != rekd_pkg::EVT_NONE)
                begin
                    pending_next = tick_evt;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.button_layout    <= 1'b0;
            cfg_reg.swap_lines       <= 1'b0;
            cfg_reg.long_press_ticks <= rekd_pkg::LONG_PRESS_RESET;
            state_reg                <= '0;
            pending_reg              <= rekd_pkg::EVT_NONE;
            out_valid_reg            <= 1'b0;
        end
        else
        begin
            cfg_reg       <= cfg_next;
            state_reg     <= state_next;
            pending_reg   <= pending_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_evt_reg <= out_evt_next;
    end

`ifndef ASSERT_OFF
    a_read_clears: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && s_axis_tuser |=> pending_reg == rekd_pkg::EVT_NONE)
        else $error("pending event not cleared by read");

    a_tick_latches: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !s_axis_tuser && tick_evt != rekd_pkg::EVT_NONE
        |=> pending_reg == out_evt_reg)
        else $error("raised event not latched as pending");

    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept |=> out_valid_reg)
        else $error("accepted request produced no result");

    a_hold_saturates: assert property (@(posedge clk) disable iff (!rst_n)
        in_accept && !s_axis_tuser && state_reg.key_held
        && state_reg.hold_count == rekd_pkg::HOLD_MAX && !s_axis_tdata[2]
        |=> state_reg.hold_count == rekd_pkg::HOLD_MAX || !state_reg.key_held)
        else $error("hold counter wrapped");
`endif

endmodule

@@ verif/tb_rotary_encoder_key_event_decoder_top.sv @@
// Testbench for rotary_encoder_key_event_decoder_top: directed and random sample/read requests
// checked against an in-bench event predictor. Depends on rekd_pkg and the RTL top level only.
`timescale 1ns / 100ps

module tb_rotary_encoder_key_event_decoder_top;

    localparam logic MODE_TICK = 1'b0;
    localparam logic MODE_READ = 1'b1;
    localparam int   WATCHDOG_LIMIT = 2000;
    localparam int   LONG_STALL = 300;

    typedef struct packed {
        logic mode;
        logic line_a;
        logic line_b;
        logic key_level;
    } sample_req_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [7:0]  s_axis_tdata = '0;    // [0] line_a, [1] line_b, [2] key_level, rest 0
    logic        s_axis_tuser = 1'b0;  // [0] mode
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [7:0]  m_axis_tdata;         // [2:0] event_code, rest 0
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    rotary_encoder_key_event_decoder_top DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // stimulus and scoreboard state
    sample_req_t         pending_reqs[$];
    rekd_pkg::evt_code_t expected_events[$];
    int          total_queued = 0;
    int          total_accepted = 0;
    int          mismatch_count = 0;
    int          stuck_cycles = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        req_taken = 1'b0;
    logic        want_long_stall = 1'b0;
    logic        long_stall_started = 1'b0;
    int          stall_left = 0;

    // pin levels the generator is currently holding
    logic gen_a = 1'b0;
    logic gen_b = 1'b0;
    logic gen_key = 1'b0;

    // predictor copy of the block
    rekd_pkg::rekd_cfg_t   model_cfg = '{button_layout: 1'b0, swap_lines: 1'b0,
                                         long_press_ticks: rekd_pkg::LONG_PRESS_RESET};
    rekd_pkg::rekd_state_t model_trk = '0;
    rekd_pkg::evt_code_t   model_latched = rekd_pkg::EVT_NONE;

    function automatic void flag_mismatch(input string what, input logic [31:0] exp_v,
                                          input logic [31:0] got_v);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("mismatch %s: expected %0h, got %0h at %0t", what, exp_v, got_v, $time);
    endfunction

    function automatic rekd_pkg::evt_code_t decode_request(input sample_req_t r);
        logic                a;
        logic                b;
        rekd_pkg::evt_code_t ev;
        ev = rekd_pkg::EVT_NONE;
        if (r.mode == MODE_READ)
        begin
            ev = model_latched;
            model_latched = rekd_pkg::EVT_NONE;
            return ev;
        end
        a = model_cfg.swap_lines ? r.line_b : r.line_a;
        b = model_cfg.swap_lines ? r.line_a : r.line_b;
        if (model_trk.key_held && model_trk.hold_count != rekd_pkg::HOLD_MAX)
            model_trk.hold_count++;
        if (model_trk.prev_key != r.key_level)
        begin
            if (!r.key_level)
            begin
                model_trk.key_held = 1'b1;
                model_trk.hold_count = '0;
            end
            else if (model_trk.key_held)
            begin
                if (model_trk.hold_count < model_cfg.long_press_ticks)
                    ev = rekd_pkg::EVT_ENTER;
                model_trk.key_held = 1'b0;
            end
        end
        if (model_trk.key_held && model_trk.hold_count >= model_cfg.long_press_ticks)
        begin
            ev = rekd_pkg::EVT_LONG;
            model_trk.key_held = 1'b0;
        end
        // falling edges only; in encoder layout B decides the direction
        if (!model_cfg.button_layout)
        begin
            if (model_trk.prev_line_a && !a)
                ev = (a != b) ? rekd_pkg::EVT_UP : rekd_pkg::EVT_DOWN;
        end
        else
        begin
            if (model_trk.prev_line_a && !a)
                ev = rekd_pkg::EVT_UP;
            if (model_trk.prev_line_b && !b)
                ev = rekd_pkg::EVT_DOWN;
        end
        model_trk.prev_line_a = a;
        model_trk.prev_line_b = b;
        model_trk.prev_key = r.key_level;
        if (ev != rekd_pkg::EVT_NONE)
            model_latched = ev;
        return ev;
    endfunction

    // sender
    always @(negedge clk)
    begin : drive_proc
        sample_req_t nxt;
        if (rst_n && (!s_axis_tvalid || req_taken))
        begin
            if (pending_reqs.size() > 0 && $urandom_range(99) >= send_idle_pct)
            begin
                nxt = pending_reqs.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata <= {5'b0, nxt.key_level, nxt.line_b, nxt.line_a};
                s_axis_tuser <= nxt.mode;
            end
            else
            begin
                s_axis_tvalid <= 1'b0;
                s_axis_tdata <= 8'($urandom);
                s_axis_tuser <= 1'($urandom_range(1));
            end
        end
    end

    // receiver, with one long hold-off on request
    always @(negedge clk)
    begin
        if (want_long_stall && !long_stall_started)
        begin
            long_stall_started <= 1'b1;
            stall_left <= LONG_STALL;
            m_axis_tready <= 1'b0;
        end
        else if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
            m_axis_tready <= rst_n && ($urandom_range(99) >= recv_stall_pct);
    end

    // monitor: results, accepted requests, register writes
    always @(posedge clk)
    begin : monitor_proc
        rekd_pkg::evt_code_t exp_ev;
        if (rst_n)
        begin
            req_taken <= s_axis_tvalid && s_axis_tready;
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (expected_events.size() == 0)
                    flag_mismatch("unexpected result", 32'h0, {24'b0, m_axis_tdata});
                else
                begin
                    exp_ev = expected_events.pop_front();
                    if (m_axis_tdata !== {5'b0, exp_ev})
                        flag_mismatch("event_code", {29'b0, exp_ev}, {24'b0, m_axis_tdata});
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                expected_events.push_back(decode_request('{mode: s_axis_tuser,
                    line_a: s_axis_tdata[0], line_b: s_axis_tdata[1],
                    key_level: s_axis_tdata[2]}));
                total_accepted++;
            end
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    rekd_pkg::REG_BUTTON_LAYOUT:
                        model_cfg.button_layout = pwdata[0];
                    rekd_pkg::REG_SWAP_LINES:
                        model_cfg.swap_lines = pwdata[0];
                    rekd_pkg::REG_LONG_PRESS_TICKS:
                        model_cfg.long_press_ticks = pwdata[7:0];
                    default: ;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stuck_cycles <= 0;
        else
            stuck_cycles <= stuck_cycles + 1;
        if (stuck_cycles == WATCHDOG_LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    function automatic void queue_req(input logic mode, input logic a, input logic b,
                                      input logic key);
        pending_reqs.push_back('{mode: mode, line_a: a, line_b: b, key_level: key});
        total_queued++;
    endfunction

    function automatic void queue_tick();
        queue_req(MODE_TICK, gen_a, gen_b, gen_key);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(1));
    endfunction

    // one quadrature step forward or back from the current line levels
    function automatic void rotate_lines(input logic fwd);
        logic [1:0] pos;
        pos = {gen_a, gen_a ^ gen_b};
        pos = fwd ? pos + 2'd1 : pos - 2'd1;
        gen_a = pos[1];
        gen_b = pos[1] ^ pos[0];
    endfunction

    function automatic void plan_random_phase(input int n_reqs, input int thr);
        int start;
        int kind;
        int pick;
        int h;
        logic fwd;
        start = total_queued;
        while (total_queued - start < n_reqs)
        begin
            kind = $urandom_range(99);
            if (kind < 30)
            begin
                fwd = rand_bit();
                repeat ($urandom_range(1, 8))
                begin
                    rotate_lines(fwd);
                    queue_tick();
                    if ($urandom_range(3) == 0)
                        queue_tick();
                end
            end
            else if (kind < 55)
            begin
                // press timed around the threshold: short, just short, exactly long
                pick = $urandom_range(3);
                if (pick == 3)
                    h = (thr <= 30) ? $urandom_range(0, thr + 3) : $urandom_range(0, 10);
                else
                    h = thr + pick - 2;
                if (h < 0)
                    h = 0;
                gen_key = 1'b0;
                queue_tick();
                repeat (h)
                begin
                    if ($urandom_range(9) == 0)
                        rotate_lines(rand_bit());
                    queue_tick();
                end
                if ($urandom_range(4) == 0)
                    rotate_lines(rand_bit());
                gen_key = 1'b1;
                queue_tick();
            end
            else if (kind < 70)
            begin
                repeat ($urandom_range(1, 2))
                    queue_req(MODE_READ, rand_bit(), rand_bit(), rand_bit());
            end
            else
            begin
                gen_a = rand_bit();
                gen_b = rand_bit();
                gen_key = rand_bit();
                queue_tick();
            end
            if ($urandom_range(9) < 4)
                queue_req(MODE_READ, rand_bit(), rand_bit(), rand_bit());
        end
    endfunction

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        logic [31:0] mask;
        mask = (idx == rekd_pkg::REG_LONG_PRESS_TICKS) ? 32'hFF : 32'h1;
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if ((prdata & mask) !== (val & mask))
            flag_mismatch("register readback", val & mask, prdata);
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic program_regs(input logic layout, input logic swap, input logic [7:0] thr);
        write_reg(rekd_pkg::REG_BUTTON_LAYOUT, {31'b0, layout});
        write_reg(rekd_pkg::REG_SWAP_LINES, {31'b0, swap});
        write_reg(rekd_pkg::REG_LONG_PRESS_TICKS, {24'b0, thr});
    endtask

    // every request returns one result, so an empty scoreboard means idle
    task automatic settle();
        @(negedge clk);
        while (total_accepted != total_queued || expected_events.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    task automatic run_phase(input logic layout, input logic swap, input int thr,
                             input int idle_pct, input int stall_pct, input logic squeeze);
        program_regs(layout, swap, thr[7:0]);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        plan_random_phase(230, thr);
        if (squeeze)
            want_long_stall = 1'b1;
        settle();
    endtask

    initial
    begin
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        program_regs(1'b0, 1'b0, 8'd3);
        // key low from power-up is not a press
        queue_req(MODE_TICK, 1'b0, 1'b0, 1'b0);
        queue_req(MODE_TICK, 1'b1, 1'b1, 1'b0);
        queue_req(MODE_READ, 1'b1, 1'b1, 1'b1);
        queue_req(MODE_TICK, 1'b0, 1'b1, 1'b1);   // A falls, B high: up
        queue_req(MODE_READ, 1'b0, 1'b0, 1'b0);
        queue_req(MODE_READ, 1'b1, 1'b0, 1'b1);
        queue_req(MODE_TICK, 1'b1, 1'b0, 1'b1);
        queue_req(MODE_TICK, 1'b0, 1'b0, 1'b1);   // A falls, B low: down
        queue_req(MODE_TICK, 1'b0, 1'b0, 1'b0);   // short press
        queue_req(MODE_TICK, 1'b0, 1'b0, 1'b0);
        queue_req(MODE_TICK, 1'b0, 1'b0, 1'b1);
        queue_req(MODE_TICK, 1'b0, 1'b0, 1'b0);   // long press
        queue_req(MODE_TICK, 1'b0, 1'b0, 1'b0);
        queue_req(MODE_TICK, 1'b0, 1'b0, 1'b0);
        queue_req(MODE_TICK, 1'b0, 1'b0, 1'b0);
        queue_req(MODE_TICK, 1'b0, 1'b0, 1'b1);
        queue_req(MODE_TICK, 1'b1, 1'b1, 1'b1);
        queue_req(MODE_TICK, 1'b1, 1'b1, 1'b0);
        queue_req(MODE_TICK, 1'b0, 1'b1, 1'b1);   // enter overwritten by up
        queue_req(MODE_READ, 1'b0, 1'b1, 1'b0);
        queue_req(MODE_READ, 1'b1, 1'b1, 1'b1);
        gen_a = 1'b0;
        gen_b = 1'b1;
        gen_key = 1'b1;
        settle();

        run_phase(1'b0, 1'b0, 100, 0, 0, 1'b0);
        run_phase(1'b1, 1'b0, 1, 56, 0, 1'b0);
        run_phase(1'b0, 1'b1, 255, 0, 56, 1'b0);
        run_phase(1'b1, 1'b1, 0, 18, 18, 1'b0);
        run_phase(1'b0, 1'b0, 7, 0, 0, 1'b1);
        run_phase(1'b1, 1'b1, 20, 56, 0, 1'b0);
        run_phase(1'b0, 1'b1, 12, 0, 56, 1'b0);

        if (mismatch_count == 0 && expected_events.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
